// ----- rtl/bqc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types, widths, codes and saturating arithmetic for the biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int CHANNELS_DEF  = 16;
  localparam int BANDS_DEF     = 16;
  localparam int COEF_FRAC_DEF = 28;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 32;
  localparam int ACC_W       = 64;
  localparam int PROD_W      = COEF_W + SAMPLE_BITS;
  localparam int CHAN_W      = 4;
  localparam int BAND_W      = 4;
  localparam int WORD_SEL_W  = 3;
  localparam int COUNT_W     = 5;
  localparam int NUM_COEFS   = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

  localparam logic signed [ACC_W-1:0] Y_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 64'sd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic {
    REQ_SAMPLE,
    REQ_WRITE
  } req_type_t;

  typedef enum logic [WORD_SEL_W-1:0] {
    WS_B0,
    WS_B1,
    WS_B2,
    WS_A1,
    WS_A2,
    WS_BYPASS,
    WS_COUNT
  } word_sel_t;

  localparam word_sel_t COEF_SEL [NUM_COEFS] = '{WS_B0, WS_B1, WS_B2, WS_A1, WS_A2};

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] mul_ext(input logic signed [COEF_W-1:0] c,
                                                      input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [PROD_W-1:0] pr;
    pr = c * x;
    return {{(ACC_W-PROD_W){pr[PROD_W-1]}}, pr};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/bqc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_in_if
// Request channel: sample or table-write request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bqc_in_if import bqc_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [CHAN_W-1:0]             channel;
  logic [BAND_W-1:0]             band;
  logic [WORD_SEL_W-1:0]         word_select;
  logic signed [COEF_W-1:0]      word_value;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (
    output valid, req_type, channel, band, word_select, word_value, sample_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, channel, band, word_select, word_value, sample_in,
    output ready
  );

endinterface
`default_nettype wire

// ----- rtl/bqc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_out_if
// Result channel: filtered sample and clip flag with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bqc_out_if import bqc_pkg::*; ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (
    output valid, sample_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, sample_out, saturated,
    output ready
  );

endinterface
`default_nettype wire

// ----- rtl/multichannel_biquad_cascade.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_biquad_cascade
// Per-channel cascade of transposed direct form II biquads, fixed point.
// ----------------------------------------------------------------------------
// A sample request runs through the active, non-bypassed sections of its
// channel and returns one saturated sample; a table-write request returns
// nothing. A sample's result is loaded into the output register once the
// sections within the band count are done, the state pipeline is empty and
// the output register is free: the loop is the multiply stage feeding the
// accumulate/round stage, whose result feeds the multiply stage of the next
// section, while the state update and write-back of each section run in a
// three-stage pipeline behind it. Coefficients, bypass flags, band counts
// and section state live in block RAMs; after reset a clearing pass over
// all CHANNELS*BANDS sections loads their reset values, and no request is
// taken until it ends. A finished result is held in an output register, so
// the next request is taken while it waits.
module multichannel_biquad_cascade import bqc_pkg::*; #(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int BANDS          = BANDS_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic     clk,
  input  logic     rst,
  bqc_in_if.sink   req,
  bqc_out_if.source rsp
);

  localparam int SECTIONS = CHANNELS * BANDS;
  localparam int SEC_AW   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W    = $clog2(BANDS + 1);
  localparam int CMP_W    = COUNT_W + 1;
  localparam logic [CMP_W-1:0]  BANDS_CMP = CMP_W'(BANDS);
  localparam logic [SEC_AW-1:0] SEC_LAST  = SEC_AW'(SECTIONS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [SEC_AW-1:0]             addr;
    logic signed [ACC_W-1:0]       p1;
    logic signed [ACC_W-1:0]       p2;
    logic signed [ACC_W-1:0]       s2;
    logic signed [COEF_W-1:0]      a1;
    logic signed [COEF_W-1:0]      a2;
    logic signed [SAMPLE_BITS-1:0] y;
  } b1_t;

  typedef struct packed {
    logic [SEC_AW-1:0]       addr;
    logic signed [ACC_W-1:0] p1;
    logic signed [ACC_W-1:0] p2;
    logic signed [ACC_W-1:0] q3;
    logic signed [ACC_W-1:0] q4;
    logic signed [ACC_W-1:0] s2;
  } b2_t;

  typedef struct packed {
    logic [SEC_AW-1:0]       addr;
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s2_new;
    logic signed [ACC_W-1:0] s2_old;
  } b3_t;

  state_t                        state;
  logic [SEC_AW-1:0]             clr_cnt;
  logic [IDX_W-1:0]              idx;
  logic [SEC_AW-1:0]             sec_addr;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic                          sat_reg;
  logic signed [ACC_W-1:0]       p0;
  logic signed [ACC_W-1:0]       p1;
  logic signed [ACC_W-1:0]       p2;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_sat;

  b1_t  b1;
  b2_t  b2;
  b3_t  b3;
  logic b1_v;
  logic b2_v;
  logic b3_v;

  logic                clearing;
  logic                accept;
  logic                tbl_wr;
  logic                smp_acc;
  logic                ch_ok;
  logic                band_ok;
  logic [SEC_AW-1:0]   wr_sec;
  logic [SEC_AW-1:0]   base_sec;
  logic [SEC_AW-1:0]   sec_next;

  logic                sec_re;
  logic [SEC_AW-1:0]   sec_raddr;
  logic [SEC_AW-1:0]   sec_waddr;

  logic [COEF_W-1:0]   coef_rd [NUM_COEFS];
  logic [0:0]          byp_rd;
  logic [COUNT_W-1:0]  cnt_rd;
  logic [2*ACC_W-1:0]  st_rd;
  logic [2*ACC_W-1:0]  st_wdata;
  logic                st_we;

  logic                cnt_we;
  logic [CH_AW-1:0]    cnt_waddr;
  logic [COUNT_W-1:0]  cnt_wdata;
  logic                byp_we;
  logic [0:0]          byp_wdata;

  logic                idx_done;
  logic                pipe_empty;
  logic                out_load;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] yw;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                y_clip;

  assign clearing = (state == ST_CLEAR);
  assign req.ready = (state == ST_IDLE);
  assign accept   = req.valid & req.ready;
  assign tbl_wr   = accept & (req.req_type == REQ_WRITE);
  assign smp_acc  = accept & (req.req_type == REQ_SAMPLE);
  assign ch_ok    = 32'(req.channel) < CHANNELS;
  assign band_ok  = 32'(req.band) < BANDS;
  assign wr_sec   = SEC_AW'(32'(req.channel) * BANDS + 32'(req.band));
  assign base_sec = SEC_AW'(32'(req.channel) * BANDS);
  assign sec_next = sec_addr + SEC_AW'(1);

  assign rsp.valid      = out_valid;
  assign rsp.sample_out = out_sample;
  assign rsp.saturated  = out_sat;

  assign idx_done   = (CMP_W'(idx) >= CMP_W'(cnt_rd)) || (CMP_W'(idx) >= BANDS_CMP);
  assign pipe_empty = !b1_v && !b2_v && !b3_v;
  assign out_load   = (state == ST_DRAIN) && pipe_empty && (!out_valid || rsp.ready);

  // section read port
  always_comb begin
    sec_re    = 1'b0;
    sec_raddr = sec_addr;
    case (state)
      ST_IDLE: begin
        if (smp_acc && ch_ok) begin
          sec_re    = 1'b1;
          sec_raddr = base_sec;
        end
      end
      ST_MUL: begin
        if (!idx_done && byp_rd[0]) begin
          sec_re    = 1'b1;
          sec_raddr = sec_next;
        end
      end
      ST_ACC: begin
        sec_re    = 1'b1;
        sec_raddr = sec_next;
      end
      default: begin
        sec_re = 1'b0;
      end
    endcase
  end

  assign sec_waddr = clearing ? clr_cnt : wr_sec;

  generate
    for (genvar k = 0; k < NUM_COEFS; k++) begin : g_coef
      logic coef_we;
      assign coef_we = clearing ||
                       (tbl_wr && ch_ok && band_ok && (req.word_select == COEF_SEL[k]));
      bqc_ram #(
        .WIDTH (COEF_W),
        .DEPTH (SECTIONS)
      ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (sec_waddr),
        .wdata (clearing ? '0 : req.word_value),
        .re    (sec_re),
        .raddr (sec_raddr),
        .rdata (coef_rd[k])
      );
    end
  endgenerate

  assign byp_we    = clearing ||
                     (tbl_wr && ch_ok && band_ok && (req.word_select == WS_BYPASS));
  assign byp_wdata = clearing ? 1'b1 : req.word_value[0];

  bqc_ram #(
    .WIDTH (1),
    .DEPTH (SECTIONS)
  ) u_bypass_ram (
    .clk   (clk),
    .we    (byp_we),
    .waddr (sec_waddr),
    .wdata (byp_wdata),
    .re    (sec_re),
    .raddr (sec_raddr),
    .rdata (byp_rd)
  );

  assign cnt_we    = clearing ? (32'(clr_cnt) < CHANNELS)
                              : (tbl_wr && ch_ok && (req.word_select == WS_COUNT));
  assign cnt_waddr = clearing ? clr_cnt[CH_AW-1:0] : CH_AW'(req.channel);
  assign cnt_wdata = clearing ? COUNT_RESET : req.word_value[COUNT_W-1:0];

  bqc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (CHANNELS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (smp_acc && ch_ok),
    .raddr (CH_AW'(req.channel)),
    .rdata (cnt_rd)
  );

  assign st_we    = clearing || b3_v;
  assign st_wdata = clearing ? '0 : {sat_add(b3.t, b3.s2_old), b3.s2_new};

  bqc_ram #(
    .WIDTH (2 * ACC_W),
    .DEPTH (SECTIONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (clearing ? clr_cnt : b3.addr),
    .wdata (st_wdata),
    .re    (sec_re),
    .raddr (sec_raddr),
    .rdata (st_rd)
  );

  // accumulate, round half up, clip
  always_comb begin
    acc     = sat_add(p0, $signed(st_rd[2*ACC_W-1:ACC_W]));
    shifted = acc >>> COEF_FRAC_BITS;
    yw      = shifted + {{(ACC_W-1){1'b0}}, acc[COEF_FRAC_BITS-1]};
    y_clip  = 1'b0;
    y_sat   = yw[SAMPLE_BITS-1:0];
    if (yw > Y_MAX) begin
      y_clip = 1'b1;
      y_sat  = Y_MAX[SAMPLE_BITS-1:0];
    end else if (yw < Y_MIN) begin
      y_clip = 1'b1;
      y_sat  = Y_MIN[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + SEC_AW'(1);
          if (clr_cnt == SEC_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (smp_acc) begin
            x_reg    <= req.sample_in;
            sat_reg  <= 1'b0;
            idx      <= '0;
            sec_addr <= base_sec;
            state    <= ch_ok ? ST_MUL : ST_DRAIN;
          end
        end
        ST_MUL: begin
          if (idx_done) begin
            state <= ST_DRAIN;
          end else if (byp_rd[0]) begin
            idx      <= idx + IDX_W'(1);
            sec_addr <= sec_next;
          end else begin
            p0    <= mul_ext($signed(coef_rd[0]), x_reg);
            p1    <= mul_ext($signed(coef_rd[1]), x_reg);
            p2    <= mul_ext($signed(coef_rd[2]), x_reg);
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          x_reg    <= y_sat;
          sat_reg  <= sat_reg | y_clip;
          idx      <= idx + IDX_W'(1);
          sec_addr <= sec_next;
          state    <= ST_MUL;
        end
        ST_DRAIN: begin
          if (out_load) begin
            out_valid  <= 1'b1;
            out_sample <= x_reg;
            out_sat    <= sat_reg;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // state update pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
    end else begin
      b1_v <= (state == ST_ACC);
      b2_v <= b1_v;
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    b1.addr <= sec_addr;
    b1.p1   <= p1;
    b1.p2   <= p2;
    b1.s2   <= $signed(st_rd[ACC_W-1:0]);
    b1.a1   <= $signed(coef_rd[3]);
    b1.a2   <= $signed(coef_rd[4]);
    b1.y    <= y_sat;

    b2.addr <= b1.addr;
    b2.p1   <= b1.p1;
    b2.p2   <= b1.p2;
    b2.q3   <= mul_ext(b1.a1, b1.y);
    b2.q4   <= mul_ext(b1.a2, b1.y);
    b2.s2   <= b1.s2;

    b3.addr   <= b2.addr;
    b3.t      <= sat_sub(b2.p1, b2.q3);
    b3.s2_new <= sat_sub(b2.p2, b2.q4);
    b3.s2_old <= b2.s2;
  end

endmodule
`default_nettype wire

// ----- rtl/bqc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bqc_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bqc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
